### src/cfte_pkg.sv
package cfte_pkg;

  // Table sizes.
  localparam int unsigned NUM_ENTRIES = 16;
  localparam int unsigned MAX_LEVELS  = 8;
  localparam int unsigned MAX_BINS    = 16;
  localparam int unsigned BIN_SLOTS   = MAX_BINS + 1;
  localparam int unsigned TALLY_DEPTH = NUM_ENTRIES * BIN_SLOTS;
  localparam int unsigned TALLY_AW    = $clog2(TALLY_DEPTH);

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_LOAD_ENTRY = 3'd0,
    CMD_LOAD_BOUND = 3'd1,
    CMD_LOAD_PART  = 3'd2,
    CMD_SCORE      = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_LEVELS      = 3'd1,
    REG_FILTER      = 3'd2,
    REG_MASK        = 3'd3,
    REG_BIN_COUNT   = 3'd4
  } reg_e;

  // Match controls shared by every entry cell.
  typedef struct packed {
    logic [3:0] levels;
    logic       filter;
    logic [7:0] mask;
    logic [3:0] path_len;
  } match_cfg_t;

  typedef logic [MAX_LEVELS-1:0][15:0] path_t;

endpackage

### src/cfte_ram.sv
module cfte_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 272
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/cfte_cell.sv
module cfte_cell (
  input  logic                clk_i,
  input  logic [3:0]          index_i,
  input  logic                enable_i,
  input  logic                we_i,
  input  logic [2:0]          level_i,
  input  logic [15:0]         cell_id_i,
  input  cfte_pkg::match_cfg_t cfg_i,
  input  cfte_pkg::path_t     path_i,
  input  logic                found_i,
  input  logic [3:0]          idx_i,
  output logic                found_o,
  output logic [3:0]          idx_o
);

  cfte_pkg::path_t cells_q;
  logic            match;

  // Path of this entry, one cell id per level.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cells_q[level_i] <= cell_id_i;
    end
  end

  // Compare the levels in use; the filter skips unmasked levels and path length.
  always_comb begin
    match = cfg_i.filter || (cfg_i.path_len == cfg_i.levels);
    for (int i = 0; i < cfte_pkg::MAX_LEVELS; i++) begin
      if ((4'(i) < cfg_i.levels) && (!cfg_i.filter || cfg_i.mask[i])
          && (cells_q[i] != path_i[i])) begin
        match = 1'b0;
      end
    end
  end

  // Pass the first match down the chain.
  assign found_o = found_i || (enable_i && match);
  assign idx_o   = found_i ? idx_i : index_i;

endmodule

### src/cell_flux_tally_engine.sv
// Channel | Direction | Handshake              | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i/in_ready_o   | cmd_i .. energy_i
// out     | out       | out_valid_o/out_ready_i | tally_value_o .. saturated_o
//
// Each item goes through accept, match and product, then tally update.
// The match runs through a chain of sixteen entry cells; the tally read-modify-write
// on the single tally RAM sets the pace.
// After reset a clearing pass writes zero to all 272 tally slots, one per cycle,
// during which no item is accepted. Configuration writes are always taken.
// A result waits in the output register; the next item is accepted meanwhile and
// holds in its update cycle until the output register is free.
module cell_flux_tally_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  entry_index_i,
  input  logic [2:0]  level_index_i,
  input  logic [15:0] cell_id_i,
  input  logic [4:0]  bin_index_i,
  input  logic [3:0]  path_len_i,
  input  logic [31:0] weight_i,
  input  logic [31:0] track_len_i,
  input  logic [31:0] energy_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] tally_value_o,
  output logic        scored_o,
  output logic [3:0]  hit_entry_o,
  output logic [4:0]  hit_bin_o,
  output logic        saturated_o
);

  localparam int unsigned AW = cfte_pkg::TALLY_AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_ACC
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [4:0] entry_count_q;
  logic [3:0] levels_q;
  logic       filter_q;
  logic [7:0] mask_q;
  logic [4:0] bin_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 5'd0;
      levels_q      <= 4'd1;
      filter_q      <= 1'b0;
      mask_q        <= 8'hFF;
      bin_count_q   <= 5'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cfte_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data_i[4:0];
        cfte_pkg::REG_LEVELS:      levels_q      <= cfg_data_i[3:0];
        cfte_pkg::REG_FILTER:      filter_q      <= cfg_data_i[0];
        cfte_pkg::REG_MASK:        mask_q        <= cfg_data_i;
        cfte_pkg::REG_BIN_COUNT:   bin_count_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Saturated register values.
  logic [4:0] ne;
  logic [3:0] nl;
  logic [4:0] nb;
  assign ne = (entry_count_q > 5'(cfte_pkg::NUM_ENTRIES)) ? 5'(cfte_pkg::NUM_ENTRIES)
                                                          : entry_count_q;
  assign nl = (levels_q > 4'(cfte_pkg::MAX_LEVELS)) ? 4'(cfte_pkg::MAX_LEVELS) : levels_q;
  assign nb = (bin_count_q > 5'(cfte_pkg::MAX_BINS)) ? 5'(cfte_pkg::MAX_BINS) : bin_count_q;

  // Clearing pass over the tally RAM after reset.
  logic [AW-1:0] clr_cnt_q;
  logic          clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_cnt_q == AW'(cfte_pkg::TALLY_DEPTH - 1)) begin
        clr_done_q <= 1'b1;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE) && clr_done_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Latched input item.
  logic [2:0]  cmd_q;
  logic [3:0]  ei_q;
  logic [2:0]  li_q;
  logic [15:0] cell_q;
  logic [4:0]  bi_q;
  logic [3:0]  plen_q;
  logic [31:0] wgt_q;
  logic [31:0] tlen_q;
  logic [31:0] erg_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      ei_q   <= entry_index_i;
      li_q   <= level_index_i;
      cell_q <= cell_id_i;
      bi_q   <= bin_index_i;
      plen_q <= path_len_i;
      wgt_q  <= weight_i;
      tlen_q <= track_len_i;
      erg_q  <= energy_i;
    end
  end

  // Energy bounds and particle path, loaded in the match cycle.
  logic [cfte_pkg::MAX_BINS-1:0][31:0] bound_q;
  cfte_pkg::path_t                      part_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      if (cmd_q == cfte_pkg::CMD_LOAD_BOUND && bi_q < 5'(cfte_pkg::MAX_BINS)) begin
        bound_q[bi_q[3:0]] <= erg_q;
      end
      if (cmd_q == cfte_pkg::CMD_LOAD_PART) begin
        part_q[li_q] <= cell_q;
      end
    end
  end

  // Chain of entry cells.
  cfte_pkg::match_cfg_t mcfg;
  assign mcfg = '{levels: nl, filter: filter_q, mask: mask_q, path_len: plen_q};

  logic [cfte_pkg::NUM_ENTRIES:0]      found_c;
  logic [cfte_pkg::NUM_ENTRIES:0][3:0] idx_c;
  assign found_c[0] = 1'b0;
  assign idx_c[0]   = 4'd0;

  for (genvar e = 0; e < cfte_pkg::NUM_ENTRIES; e++) begin : g_cell
    cfte_cell u_cell (
      .clk_i     (clk_i),
      .index_i   (4'(e)),
      .enable_i  (5'(e) < ne),
      .we_i      ((state_q == S_CALC) && (cmd_q == cfte_pkg::CMD_LOAD_ENTRY)
                  && (ei_q == 4'(e))),
      .level_i   (li_q),
      .cell_id_i (cell_q),
      .cfg_i     (mcfg),
      .path_i    (part_q),
      .found_i   (found_c[e]),
      .idx_i     (idx_c[e]),
      .found_o   (found_c[e+1]),
      .idx_o     (idx_c[e+1])
    );
  end

  // First bin whose bound exceeds the energy, else the overflow bin.
  logic [4:0] bin_c;
  always_comb begin
    bin_c = nb;
    for (int j = cfte_pkg::MAX_BINS - 1; j >= 0; j--) begin
      if ((5'(j) < nb) && (erg_q < bound_q[j])) begin
        bin_c = 5'(j);
      end
    end
  end

  // Tally address for the score or the read.
  logic [3:0]    ent_c;
  logic [4:0]    slot_c;
  logic [AW-1:0] addr_c;
  logic          rd_ok_c;
  always_comb begin
    ent_c   = (cmd_q == cfte_pkg::CMD_SCORE) ? idx_c[cfte_pkg::NUM_ENTRIES] : ei_q;
    slot_c  = (cmd_q == cfte_pkg::CMD_SCORE) ? bin_c : bi_q;
    rd_ok_c = (bi_q <= 5'(cfte_pkg::MAX_BINS));
    if (cmd_q == cfte_pkg::CMD_READ && !rd_ok_c) begin
      slot_c = 5'd0;
    end
    addr_c = AW'({ent_c, 4'd0}) + AW'(ent_c) + AW'(slot_c);
  end

  logic          found_q;
  logic [3:0]    hit_q;
  logic [4:0]    bin_q;
  logic [AW-1:0] addr_q;
  logic          rd_ok_q;
  logic [63:0]   prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      found_q <= found_c[cfte_pkg::NUM_ENTRIES];
      hit_q   <= idx_c[cfte_pkg::NUM_ENTRIES];
      bin_q   <= bin_c;
      addr_q  <= addr_c;
      rd_ok_q <= rd_ok_c;
      prod_q  <= 64'(wgt_q) * 64'(tlen_q);
    end
  end

  // Tally RAM with saturating update.
  logic          advance;
  logic          score_we;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;
  logic [64:0]   sum_w;
  logic          sat;
  logic [63:0]   sum_sat;

  assign advance   = (state_q == S_ACC) && (!out_valid_o || out_ready_i);
  assign sum_w     = {1'b0, ram_rdata} + {1'b0, prod_q};
  assign sat       = sum_w[64];
  assign sum_sat   = sat ? '1 : sum_w[63:0];
  assign score_we  = advance && (cmd_q == cfte_pkg::CMD_SCORE) && found_q;
  assign ram_we    = !clr_done_q || score_we;
  assign ram_waddr = clr_done_q ? addr_q : clr_cnt_q;
  assign ram_wdata = clr_done_q ? sum_sat : '0;
  assign ram_raddr = (state_q == S_CALC) ? addr_c : addr_q;

  cfte_ram #(
    .WIDTH (64),
    .DEPTH (cfte_pkg::TALLY_DEPTH)
  ) u_tally_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, output register and result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_o   <= 1'b0;
      tally_value_o <= '0;
      scored_o      <= 1'b0;
      hit_entry_o   <= 4'd0;
      hit_bin_o     <= 5'd0;
      saturated_o   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (advance) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (advance) begin
        if (cmd_q == cfte_pkg::CMD_SCORE && found_q) begin
          tally_value_o <= sum_sat;
          scored_o      <= 1'b1;
          hit_entry_o   <= hit_q;
          hit_bin_o     <= bin_q;
          saturated_o   <= sat;
        end else begin
          tally_value_o <= (cmd_q == cfte_pkg::CMD_READ && rd_ok_q) ? ram_rdata : '0;
          scored_o      <= 1'b0;
          hit_entry_o   <= 4'd0;
          hit_bin_o     <= 5'd0;
          saturated_o   <= 1'b0;
        end
      end
    end
  end

  // Checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done_q |-> !in_ready_o)
    else $error("item accepted during tally clearing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CALC))
    else $error("accepted item did not enter the match cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (scored_o && (tally_value_o == '1)))
    else $error("saturated result without a full-scale score");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scored_o) |-> (5'(hit_entry_o) < ne))
    else $error("score hit an entry beyond the entries in use");

endmodule
